// ===== design/dfs_maze_walk_generator_assert.svh =====
// Assertion macros for the maze walk generator.
// No dependencies; included by the top level only.
`ifndef DFS_MAZE_WALK_GENERATOR_ASSERT_SVH
`define DFS_MAZE_WALK_GENERATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define DMW_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("maze walk assertion failed");
`define DMW_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("maze walk assertion failed");
`else
`define DMW_ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define DMW_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/dmw_pkg.sv =====
// Shared constants and types of the maze walk generator.
// No dependencies; imported by the top level, dmw_nbr and the testbench.
package dmw_pkg;

	localparam int unsigned MAX_GRID_W_DEF = 64;
	localparam int unsigned MAX_GRID_H_DEF = 64;

	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 7;
	localparam int unsigned DIM_W      = 7;
	localparam int unsigned KIND_W     = 1;
	localparam int unsigned RND_W      = 16;
	localparam int unsigned COORD_W    = 6;

	localparam logic [DIM_W-1:0] GRID_DIM_RST = 7'd64;

	localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;

	localparam logic [KIND_W-1:0] KIND_START = 1'b0;
	localparam logic [KIND_W-1:0] KIND_STEP  = 1'b1;

	typedef enum logic [1:0] {
		DIR_UP,
		DIR_RIGHT,
		DIR_DOWN,
		DIR_LEFT
	} dir_t;

	typedef struct packed {
		logic found;
		dir_t dir;
	} pick_t;

endpackage

// ===== design/dfs_maze_walk_generator.sv =====
// Top level of the maze walk generator: sequencer, visited banks, walk stack.
// Depends on dmw_pkg, dmw_ram, dmw_nbr and the assertion header.
//
//   channel   signals                             moves
//   config    cfg_we cfg_index cfg_data           grid_width, grid_height writes
//   input     in_valid in_stall kind random_word  one start or step per transfer
//   output    out_valid out_stall cell_x cell_y   one cell per step on a live stack
//             last
//
// A step reads the visited rows around the stack top at the input transfer and writes
// the picked row back when it leaves ST_EVAL, the state after ST_IDLE.
// A start passes through ST_EVAL into a clear pass over the ((MAX_GRID_H+1)/2+1)/2 rows
// of each visited bank, one row of each bank per cycle; in_stall stays high during it.
// After reset the visited map is unwritten and the stack is empty; a start clears the map and pushes the origin.
// A step with a result holds in ST_EVAL while out_valid and out_stall are high.
`include "dfs_maze_walk_generator_assert.svh"
module dfs_maze_walk_generator #(
	parameter int unsigned MAX_GRID_W = dmw_pkg::MAX_GRID_W_DEF,
	parameter int unsigned MAX_GRID_H = dmw_pkg::MAX_GRID_H_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [dmw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dmw_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [dmw_pkg::KIND_W-1:0]     kind,
	input  logic [dmw_pkg::RND_W-1:0]      random_word,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [dmw_pkg::COORD_W-1:0]    cell_x,
	output logic [dmw_pkg::COORD_W-1:0]    cell_y,
	output logic                          last
);
	import dmw_pkg::*;

	localparam int unsigned CELL_COLS  = (MAX_GRID_W + 1) / 2;
	localparam int unsigned CELL_ROWS  = (MAX_GRID_H + 1) / 2;
	localparam int unsigned CELL_TOTAL = CELL_COLS * CELL_ROWS;
	localparam int unsigned CX_W       = $clog2(CELL_COLS);
	localparam int unsigned CY_W       = $clog2(CELL_ROWS);
	localparam int unsigned BANK_DEPTH = (CELL_ROWS + 1) / 2;
	localparam int unsigned BA_W       = $clog2(BANK_DEPTH);
	localparam int unsigned SA_W       = $clog2(CELL_TOTAL);
	localparam int unsigned SC_W       = $clog2(CELL_TOTAL + 1);
	localparam int unsigned ENT_W      = CY_W + CX_W;
	localparam int unsigned MW         = (CX_W > CY_W) ? CX_W : CY_W;
	localparam int unsigned CW         = ((MW > 6) ? MW : 6) + 2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_CLEAR
	} state_t;

	state_t              state_q;
	logic [DIM_W-1:0]    grid_width_q, grid_height_q;
	logic [KIND_W-1:0]   kind_q;
	logic [RND_W-1:0]    rnd_q;
	logic [CX_W-1:0]     top_cx_q;
	logic [CY_W-1:0]     top_cy_q;
	logic [SC_W-1:0]     count_q;
	logic [BA_W-1:0]     clr_addr_q;
	logic                out_valid_q, last_q;
	logic [COORD_W-1:0]  cell_x_q, cell_y_q;

	logic                par;
	logic [CY_W:0]       cy_ext, up_row, dn_row;
	logic [BA_W-1:0]     addr_cur, addr_up, addr_dn;
	logic [CW-1:0]       gw, gh;

	logic                b0_we, b1_we;
	logic [BA_W-1:0]     b0_waddr, b1_waddr, b0_raddr_a, b1_raddr_a;
	logic [CELL_COLS-1:0] b0_wdata, b1_wdata, b0_rdata_a, b0_rdata_b, b1_rdata_a, b1_rdata_b;
	logic [CELL_COLS-1:0] row_cur, row_up, row_dn;

	pick_t               pick;
	logic                produce, out_free, eval_go, out_load, is_pop, can_push;
	logic [CELL_COLS-1:0] wr_base, wr_data;
	logic [CX_W-1:0]     wr_col, next_cx;
	logic [CY_W-1:0]     next_cy;
	logic [BA_W-1:0]     wr_addr;
	logic                wr_bank;

	logic                stk_we;
	logic [SA_W-1:0]     stk_waddr, stk_raddr;
	logic [ENT_W-1:0]    stk_wdata, stk_rdata;
	logic [SC_W-1:0]     cnt_m2;
	logic [CX_W+6:0]     xw;
	logic [CY_W+6:0]     yw;

	assign par      = top_cy_q[0];
	assign cy_ext   = {1'b0, top_cy_q};
	assign up_row   = cy_ext + (CY_W+1)'(1);
	assign dn_row   = cy_ext - (CY_W+1)'(1);
	assign addr_cur = cy_ext[BA_W:1];
	assign addr_up  = up_row[BA_W:1];
	assign addr_dn  = dn_row[BA_W:1];

	assign gw = (CW'(grid_width_q) > CW'(MAX_GRID_W)) ? CW'(MAX_GRID_W) : CW'(grid_width_q);
	assign gh = (CW'(grid_height_q) > CW'(MAX_GRID_H)) ? CW'(MAX_GRID_H) : CW'(grid_height_q);

	assign b0_raddr_a = par ? addr_dn : addr_cur;
	assign b1_raddr_a = par ? addr_cur : addr_dn;

	assign row_cur = par ? b1_rdata_a : b0_rdata_a;
	assign row_dn  = par ? b0_rdata_a : b1_rdata_a;
	assign row_up  = par ? b0_rdata_b : b1_rdata_b;

	dmw_nbr #(
		.CX_W (CX_W),
		.CY_W (CY_W),
		.CW   (CW),
		.COLS (CELL_COLS)
	) u_nbr (
		.cx      (top_cx_q),
		.cy      (top_cy_q),
		.gw      (gw),
		.gh      (gh),
		.row_cur (row_cur),
		.row_up  (row_up),
		.row_dn  (row_dn),
		.rnd     (rnd_q),
		.pick    (pick)
	);

	assign produce  = (kind_q == KIND_STEP) && (count_q != '0);
	assign out_free = !out_valid_q || !out_stall;
	assign eval_go  = (state_q == ST_EVAL) && (!produce || out_free);
	assign out_load = eval_go && produce;
	assign is_pop   = !pick.found;
	assign can_push = count_q < SC_W'(CELL_TOTAL);
	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		unique case (pick.dir)
			DIR_UP: begin
				wr_base = row_up;
				wr_col  = top_cx_q;
				wr_addr = addr_up;
				wr_bank = !par;
				next_cx = top_cx_q;
				next_cy = top_cy_q + CY_W'(1);
			end
			DIR_RIGHT: begin
				wr_base = row_cur;
				wr_col  = top_cx_q + CX_W'(1);
				wr_addr = addr_cur;
				wr_bank = par;
				next_cx = top_cx_q + CX_W'(1);
				next_cy = top_cy_q;
			end
			DIR_DOWN: begin
				wr_base = row_dn;
				wr_col  = top_cx_q;
				wr_addr = addr_dn;
				wr_bank = !par;
				next_cx = top_cx_q;
				next_cy = top_cy_q - CY_W'(1);
			end
			DIR_LEFT: begin
				wr_base = row_cur;
				wr_col  = top_cx_q - CX_W'(1);
				wr_addr = addr_cur;
				wr_bank = par;
				next_cx = top_cx_q - CX_W'(1);
				next_cy = top_cy_q;
			end
			default: begin
				wr_base = row_cur;
				wr_col  = top_cx_q;
				wr_addr = addr_cur;
				wr_bank = par;
				next_cx = top_cx_q;
				next_cy = top_cy_q;
			end
		endcase
	end

	assign wr_data = wr_base | (CELL_COLS'(1) << wr_col);

	always_comb begin
		b0_we    = 1'b0;
		b1_we    = 1'b0;
		b0_waddr = wr_addr;
		b1_waddr = wr_addr;
		b0_wdata = wr_data;
		b1_wdata = wr_data;
		if (state_q == ST_CLEAR) begin
			b0_we    = 1'b1;
			b1_we    = 1'b1;
			b0_waddr = clr_addr_q;
			b1_waddr = clr_addr_q;
			b0_wdata = (clr_addr_q == '0) ? CELL_COLS'(1) : '0;
			b1_wdata = '0;
		end else if (out_load && pick.found) begin
			b0_we = !wr_bank;
			b1_we = wr_bank;
		end
	end

	assign cnt_m2    = count_q - SC_W'(2);
	assign stk_raddr = cnt_m2[SA_W-1:0];
	assign stk_we    = eval_go && ((kind_q == KIND_START) || (produce && pick.found && can_push));
	assign stk_waddr = (kind_q == KIND_START) ? '0 : count_q[SA_W-1:0];
	assign stk_wdata = (kind_q == KIND_START) ? '0 : {next_cy, next_cx};

	dmw_ram #(
		.WIDTH (CELL_COLS),
		.DEPTH (BANK_DEPTH)
	) u_bank0 (
		.clk     (clk),
		.we      (b0_we),
		.waddr   (b0_waddr),
		.wdata   (b0_wdata),
		.raddr_a (b0_raddr_a),
		.rdata_a (b0_rdata_a),
		.raddr_b (addr_up),
		.rdata_b (b0_rdata_b)
	);

	dmw_ram #(
		.WIDTH (CELL_COLS),
		.DEPTH (BANK_DEPTH)
	) u_bank1 (
		.clk     (clk),
		.we      (b1_we),
		.waddr   (b1_waddr),
		.wdata   (b1_wdata),
		.raddr_a (b1_raddr_a),
		.rdata_a (b1_rdata_a),
		.raddr_b (addr_up),
		.rdata_b (b1_rdata_b)
	);

	dmw_ram #(
		.WIDTH (ENT_W),
		.DEPTH (CELL_TOTAL)
	) u_stack (
		.clk     (clk),
		.we      (stk_we),
		.waddr   (stk_waddr),
		.wdata   (stk_wdata),
		.raddr_a (stk_raddr),
		.rdata_a (stk_rdata),
		.raddr_b (stk_raddr),
		.rdata_b ()
	);

	assign xw = {6'd0, top_cx_q, 1'b0};
	assign yw = {6'd0, top_cy_q, 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			grid_width_q  <= GRID_DIM_RST;
			grid_height_q <= GRID_DIM_RST;
			kind_q        <= KIND_START;
			rnd_q         <= '0;
			top_cx_q      <= '0;
			top_cy_q      <= '0;
			count_q       <= '0;
			clr_addr_q    <= '0;
			out_valid_q   <= 1'b0;
			last_q        <= 1'b0;
			cell_x_q      <= '0;
			cell_y_q      <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_GRID_WIDTH:  grid_width_q  <= cfg_data;
					REG_GRID_HEIGHT: grid_height_q <= cfg_data;
				endcase
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
				cell_x_q    <= xw[COORD_W-1:0];
				cell_y_q    <= yw[COORD_W-1:0];
				last_q      <= is_pop && (count_q == SC_W'(1));
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						kind_q  <= kind;
						rnd_q   <= random_word;
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if (eval_go) begin
						if (kind_q == KIND_START) begin
							count_q    <= SC_W'(1);
							top_cx_q   <= '0;
							top_cy_q   <= '0;
							clr_addr_q <= '0;
							state_q    <= ST_CLEAR;
						end else begin
							if (produce) begin
								if (pick.found) begin
									if (can_push) begin
										count_q  <= count_q + SC_W'(1);
										top_cx_q <= next_cx;
										top_cy_q <= next_cy;
									end
								end else begin
									count_q  <= count_q - SC_W'(1);
									top_cx_q <= stk_rdata[CX_W-1:0];
									top_cy_q <= stk_rdata[ENT_W-1:CX_W];
								end
							end
							state_q <= ST_IDLE;
						end
					end
				end
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + BA_W'(1);
					if (clr_addr_q == BA_W'(BANK_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign cell_x    = cell_x_q;
	assign cell_y    = cell_y_q;
	assign last      = last_q;

	`DMW_ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= SC_W'(CELL_TOTAL))
	`DMW_ASSERT_ALWAYS(a_one_bank_per_step, clk, arst_n, !((state_q == ST_EVAL) && b0_we && b1_we))
	`DMW_ASSERT_IMPL(a_clear_holds_origin, clk, arst_n, state_q == ST_CLEAR, (count_q == SC_W'(1)) && (top_cx_q == '0) && (top_cy_q == '0))

endmodule

// ===== design/dmw_ram.sv =====
// Generic single-write, dual-read RAM with registered read data.
// No dependencies; used for the visited banks and the walk stack.
module dmw_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr_a,
	output logic [WIDTH-1:0] rdata_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

// ===== design/dmw_nbr.sv =====
// Neighbor check and random pick for one walk step.
// Depends on dmw_pkg for pick_t and the direction codes.
module dmw_nbr #(
	parameter int unsigned CX_W = 5,
	parameter int unsigned CY_W = 5,
	parameter int unsigned CW   = 8,
	parameter int unsigned COLS = 32
) (
	input  logic [CX_W-1:0]             cx,
	input  logic [CY_W-1:0]             cy,
	input  logic [CW-1:0]               gw,
	input  logic [CW-1:0]               gh,
	input  logic [COLS-1:0]             row_cur,
	input  logic [COLS-1:0]             row_up,
	input  logic [COLS-1:0]             row_dn,
	input  logic [dmw_pkg::RND_W-1:0]   rnd,
	output dmw_pkg::pick_t              pick
);
	import dmw_pkg::*;

	logic [CW-1:0]   x, y, xp, xm, yp, ym;
	logic [CX_W:0]   cxp, cxm;
	logic [COLS-1:0] sh_r, sh_l;
	logic [3:0]      open;
	logic [2:0]      cnt;
	logic [18:0]     prod;
	logic [2:0]      sel;
	logic [2:0]      rank;

	assign x    = CW'({cx, 1'b0});
	assign y    = CW'({cy, 1'b0});
	assign xp   = x + CW'(2);
	assign xm   = x - CW'(2);
	assign yp   = y + CW'(2);
	assign ym   = y - CW'(2);
	assign cxp  = {1'b0, cx} + (CX_W+1)'(1);
	assign cxm  = {1'b0, cx} - (CX_W+1)'(1);
	assign sh_r = row_cur >> cxp;
	assign sh_l = row_cur >> cxm;

	assign open[DIR_UP]    = (x < gw) && (yp < gh) && !row_up[cx];
	assign open[DIR_RIGHT] = (xp < gw) && (y < gh) && !sh_r[0];
	assign open[DIR_DOWN]  = (cy != '0) && (x < gw) && (ym < gh) && !row_dn[cx];
	assign open[DIR_LEFT]  = (cx != '0) && (xm < gw) && (y < gh) && !sh_l[0];

	assign cnt  = 3'(open[0]) + 3'(open[1]) + 3'(open[2]) + 3'(open[3]);
	assign prod = 19'(rnd) * 19'(cnt);
	assign sel  = prod[18:16];

	always_comb begin
		rank       = '0;
		pick.found = (cnt != '0);
		pick.dir   = DIR_UP;
		for (int i = 0; i < 4; i++) begin
			if (open[i]) begin
				if (rank == sel) begin
					pick.dir = dir_t'(2'(i));
				end
				rank = rank + 3'd1;
			end
		end
	end

endmodule

// ===== dv/tb_dfs_maze_walk_generator.sv =====
// Self-checking testbench for the maze walk generator: drives starts and steps,
// predicts every reported cell with its own depth-first walk model.
// Depends on dmw_pkg and dfs_maze_walk_generator.
module tb_dfs_maze_walk_generator;
	timeunit 1ns;
	timeprecision 1ps;
	import dmw_pkg::*;

	localparam int CELL_COLS    = (MAX_GRID_W_DEF + 1) / 2;
	localparam int CELL_ROWS    = (MAX_GRID_H_DEF + 1) / 2;
	localparam int CELL_TOTAL   = CELL_COLS * CELL_ROWS;
	localparam int CELL_IDX_W   = $clog2(CELL_TOTAL);
	localparam int DRAIN_CYCLES = 2 * (((MAX_GRID_H_DEF + 1) / 2 + 1) / 2) + 10;

	typedef struct {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic               last;
	} cell_rec_t;

	logic                  clk         = 1'b0;
	logic                  arst_n      = 1'b0;
	logic                  cfg_we      = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index   = REG_GRID_WIDTH;
	logic [CFG_DATA_W-1:0] cfg_data    = '0;
	logic                  in_valid    = 1'b0;
	logic                  in_stall;
	logic [KIND_W-1:0]     kind        = KIND_START;
	logic [RND_W-1:0]      random_word = '0;
	logic                  out_valid;
	logic                  out_stall   = 1'b0;
	logic [COORD_W-1:0]    cell_x;
	logic [COORD_W-1:0]    cell_y;
	logic                  last;

	logic [DIM_W-1:0]      grid_w_reg = GRID_DIM_RST;
	logic [DIM_W-1:0]      grid_h_reg = GRID_DIM_RST;
	bit                    seen_cell [CELL_TOTAL];
	logic [CELL_IDX_W-1:0] path_stack [CELL_TOTAL];
	int                    path_depth = 0;
	cell_rec_t             expected_cells [$];
	int                    err_count = 0;
	int                    src_idle_pct = 0;
	int                    sink_stall_pct = 0;

	dfs_maze_walk_generator u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.kind        (kind),
		.random_word (random_word),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.cell_x      (cell_x),
		.cell_y      (cell_y),
		.last        (last)
	);

	always #1 clk = ~clk;

	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < sink_stall_pct);
	end

	always @(posedge clk) begin
		cell_rec_t exp_cell;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_cells.size() == 0) begin
				$error("unexpected cell transfer: x %0d y %0d last %0d", cell_x, cell_y, last);
				err_count++;
			end else begin
				exp_cell = expected_cells.pop_front();
				if (cell_x !== exp_cell.x) begin
					$error("cell_x mismatch: expected %0d, got %0d", exp_cell.x, cell_x);
					err_count++;
				end
				if (cell_y !== exp_cell.y) begin
					$error("cell_y mismatch: expected %0d, got %0d", exp_cell.y, cell_y);
					err_count++;
				end
				if (last !== exp_cell.last) begin
					$error("last mismatch: expected %0d, got %0d", exp_cell.last, last);
					err_count++;
				end
			end
		end
	end

	function automatic void predict_walk_step(logic [KIND_W-1:0] k, logic [RND_W-1:0] rnd);
		int        w, h, top, x, y, nx, ny, idx, n_open, pick, i;
		int        open_cells [4];
		cell_rec_t rec;
		if (k == KIND_START) begin
			foreach (seen_cell[j])
				seen_cell[j] = 1'b0;
			path_stack[0] = '0;
			seen_cell[0]  = 1'b1;
			path_depth    = 1;
			return;
		end
		if (path_depth == 0)
			return;
		w   = (int'(grid_w_reg) > int'(MAX_GRID_W_DEF)) ? int'(MAX_GRID_W_DEF) : int'(grid_w_reg);
		h   = (int'(grid_h_reg) > int'(MAX_GRID_H_DEF)) ? int'(MAX_GRID_H_DEF) : int'(grid_h_reg);
		top = int'(path_stack[path_depth - 1]);
		x   = (top % CELL_COLS) * 2;
		y   = (top / CELL_COLS) * 2;
		rec.x    = x[COORD_W-1:0];
		rec.y    = y[COORD_W-1:0];
		rec.last = 1'b0;
		n_open = 0;
		for (i = 0; i < 4; i++) begin
			nx = x;
			ny = y;
			case (dir_t'(i))
				DIR_UP:    ny = y + 2;
				DIR_RIGHT: nx = x + 2;
				DIR_DOWN:  ny = y - 2;
				DIR_LEFT:  nx = x - 2;
			endcase
			if (nx >= 0 && ny >= 0 && nx < w && ny < h) begin
				idx = (ny / 2) * CELL_COLS + nx / 2;
				if (!seen_cell[idx]) begin
					open_cells[n_open] = idx;
					n_open++;
				end
			end
		end
		if (n_open > 0) begin
			pick = (int'(rnd) * n_open) >> 16;
			seen_cell[open_cells[pick]] = 1'b1;
			if (path_depth < CELL_TOTAL) begin
				path_stack[path_depth] = CELL_IDX_W'(open_cells[pick]);
				path_depth++;
			end
		end else begin
			path_depth--;
			if (path_depth == 0)
				rec.last = 1'b1;
		end
		expected_cells.insert(expected_cells.size(), rec);
	endfunction

	task automatic send_item(logic [KIND_W-1:0] k, logic [RND_W-1:0] r);
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid    <= 1'b1;
		kind        <= k;
		random_word <= r;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_walk_step(k, r);
		@(negedge clk);
	endtask

	task automatic wait_walk_idle();
		in_valid <= 1'b0;
		while (expected_cells.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_grid_size(logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h);
		cfg_we    <= 1'b1;
		cfg_index <= REG_GRID_WIDTH;
		cfg_data  <= w;
		@(negedge clk);
		cfg_index <= REG_GRID_HEIGHT;
		cfg_data  <= h;
		@(negedge clk);
		cfg_we     <= 1'b0;
		grid_w_reg = w;
		grid_h_reg = h;
	endtask

	task automatic test_default_grid();
		send_item(KIND_STEP, 16'h0000);
		send_item(KIND_START, 16'hFFFF);
		send_item(KIND_STEP, 16'h0000);
		send_item(KIND_STEP, 16'hFFFF);
		send_item(KIND_STEP, 16'h8000);
		send_item(KIND_STEP, 16'h5555);
		send_item(KIND_START, 16'h0000);
		send_item(KIND_STEP, 16'hFFFF);
		send_item(KIND_STEP, 16'h0000);
	endtask

	task automatic test_tiny_grids();
		wait_walk_idle();
		write_grid_size(7'd0, 7'd0);
		send_item(KIND_START, 16'h1234);
		send_item(KIND_STEP, 16'hFFFF);
		send_item(KIND_STEP, 16'h0000);
		wait_walk_idle();
		write_grid_size(7'd2, 7'd1);
		send_item(KIND_START, 16'h0000);
		send_item(KIND_STEP, 16'h0000);
		wait_walk_idle();
		write_grid_size(7'd3, 7'd3);
		send_item(KIND_START, 16'h0000);
		while (path_depth != 0)
			send_item(KIND_STEP, RND_W'($urandom));
		send_item(KIND_STEP, 16'hFFFF);
		wait_walk_idle();
		write_grid_size(7'd127, 7'd127);
		send_item(KIND_START, 16'h0000);
		send_item(KIND_STEP, 16'hFFFF);
	endtask

	task automatic test_random_walks(int idle_pct, int stall_pct, int n_items);
		int                    sent, size_sel, mode, steps, limit, resize_at;
		logic [CFG_DATA_W-1:0] w, h;
		src_idle_pct   = idle_pct;
		sink_stall_pct = stall_pct;
		sent = 0;
		while (sent < n_items) begin
			wait_walk_idle();
			size_sel = $urandom_range(99);
			if (size_sel < 8) begin
				w = CFG_DATA_W'($urandom_range(4));
				h = CFG_DATA_W'($urandom_range(4));
			end else if (size_sel < 16) begin
				w = CFG_DATA_W'($urandom_range(127, 64));
				h = CFG_DATA_W'($urandom_range(127, 64));
			end else begin
				w = CFG_DATA_W'($urandom_range(20, 5));
				h = CFG_DATA_W'($urandom_range(20, 5));
			end
			write_grid_size(w, h);
			send_item(KIND_START, RND_W'($urandom));
			sent++;
			mode      = $urandom_range(99);
			limit     = (size_sel >= 8 && size_sel < 16) ? $urandom_range(250, 40) : 1 << 30;
			resize_at = (mode >= 85) ? $urandom_range(20, 1) : -1;
			if (mode < 15)
				limit = $urandom_range(30, 1);
			steps = 0;
			while (path_depth != 0 && steps < limit && sent < n_items) begin
				if (steps == resize_at) begin
					wait_walk_idle();
					write_grid_size(CFG_DATA_W'($urandom_range(20)),
						CFG_DATA_W'($urandom_range(20)));
				end
				if ($urandom_range(99) == 0)
					send_item(KIND_START, RND_W'($urandom));
				else
					send_item(KIND_STEP, RND_W'($urandom));
				steps++;
				sent++;
			end
			repeat ($urandom_range(2)) begin
				if (path_depth == 0) begin
					send_item(KIND_STEP, RND_W'($urandom));
					sent++;
				end
			end
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (DRAIN_CYCLES) @(negedge clk);
		test_default_grid();
		test_tiny_grids();
		test_random_walks(0, 0, 380);
		test_random_walks(71, 0, 380);
		test_random_walks(0, 71, 380);
		test_random_walks(19, 19, 380);
		wait_walk_idle();
		if (err_count == 0 && expected_cells.size() == 0) begin
			$display("tb_dfs_maze_walk_generator: PASS");
		end else begin
			$display("tb_dfs_maze_walk_generator: FAIL");
		end
		$finish;
	end

	initial begin
		#1_000_000;
		$display("tb_dfs_maze_walk_generator: FAIL");
		$finish;
	end

endmodule
